### rtl/core/bitmap_page_frame_allocator_assert.svh
// Assertion macros shared by the page frame allocator modules.
// No dependencies; included by the controller and the datapath.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpfa assertion failed");

// next-cycle implication
`define BPFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpfa assertion failed");

`endif

### rtl/core/bpfa_pkg.sv
// Package of the bitmap page frame allocator: codes, command/status types, helpers.
// No dependencies; used by bpfa_ctrl, bpfa_dpath and the top level.
package bpfa_pkg;

    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int ADDR_W       = 32;
    localparam int CFG_W        = 16;
    localparam int FRAME_ADDR_W = 27;
    localparam int FREE_BYTES_W = 28;
    localparam int WORD_W       = 64;
    localparam int BIT_W        = 6;

    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM          = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

    localparam logic [CFG_W-1:0] RESERVED_RST = 16'd4096;

    typedef struct packed {
        logic accept;
        logic sweep_start;
        logic sweep_clear;
        logic sweep_step;
        logic alloc_grp;
        logic alloc_word;
        logic alloc_upd;
        logic free_rd;
        logic free_upd;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic grp_none;
        logic alloc_ok;
        logic range_err;
        logic already_free;
    } t_sts;

    // {found, index} of the lowest clear bit
    function automatic logic [BIT_W:0] first_zero(input logic [WORD_W-1:0] word);
        logic [BIT_W:0] res;
        res = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word[i]) res = {1'b1, BIT_W'(i)};
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W-1:0] n);
        return (WORD_W'(1) << n) - WORD_W'(1);
    endfunction

endpackage

### rtl/core/bpfa_ctrl.sv
// Controller FSM of the page frame allocator: sequences sweeps, alloc and free.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_assert.svh.
`include "bitmap_page_frame_allocator_assert.svh"

module bpfa_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bpfa_pkg::MODE_W-1:0]    i_mode,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bpfa_pkg::STATUS_W-1:0]  o_status,
    output bpfa_pkg::t_cmd                 o_cmd,
    input  bpfa_pkg::t_sts                 i_sts
);

    localparam logic [3:0] S_BOOT  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_IDLE  = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_A_GRP = 4'd4;
    localparam logic [3:0] S_A_SUM = 4'd5;
    localparam logic [3:0] S_A_MAP = 4'd6;
    localparam logic [3:0] S_F_RD  = 4'd7;
    localparam logic [3:0] S_F_UPD = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]                     r_state, n_state;
    logic [bpfa_pkg::STATUS_W-1:0]  r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_BOOT: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.sweep_clear = 1'b1;
                n_state = S_CLEAR;
            end
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_mode)
                        bpfa_pkg::MODE_INIT: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state = S_INIT;
                        end
                        bpfa_pkg::MODE_ALLOC: n_state = S_A_GRP;
                        bpfa_pkg::MODE_FREE:  n_state = S_F_RD;
                        default: begin
                            n_status = bpfa_pkg::ST_OK;
                            n_state  = S_OUT;
                        end
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_status = bpfa_pkg::ST_OK;
                    n_state  = S_OUT;
                end
            end
            S_A_GRP: begin
                o_cmd.alloc_grp = 1'b1;
                if (i_sts.grp_none) begin
                    n_status = bpfa_pkg::ST_OOM;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_A_SUM;
                end
            end
            S_A_SUM: begin
                o_cmd.alloc_word = 1'b1;
                n_state = S_A_MAP;
            end
            S_A_MAP: begin
                o_cmd.alloc_upd = 1'b1;
                n_status = i_sts.alloc_ok ? bpfa_pkg::ST_OK : bpfa_pkg::ST_OOM;
                n_state  = S_OUT;
            end
            S_F_RD: begin
                o_cmd.free_rd = 1'b1;
                if (i_sts.range_err) begin
                    n_status = bpfa_pkg::ST_RANGE;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_F_UPD;
                end
            end
            S_F_UPD: begin
                o_cmd.free_upd = 1'b1;
                n_status = i_sts.already_free ? bpfa_pkg::ST_ALREADY_FREE
                                              : bpfa_pkg::ST_OK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BOOT;
            r_status <= bpfa_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_status;

    `BPFA_ASSERT_IMP(a_one_side, i_clk, i_rst_n, o_out_valid, !o_in_ready)

endmodule

### rtl/core/bpfa_dpath.sv
// Datapath of the page frame allocator: used map, full-word summary, count, result.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_assert.svh.
`include "bitmap_page_frame_allocator_assert.svh"

module bpfa_dpath #(
    parameter int NUM_FRAMES  = 32768,
    parameter int FRAME_BYTES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bpfa_pkg::t_cmd                     i_cmd,
    output bpfa_pkg::t_sts                     o_sts,
    input  logic                               i_cfg_we,
    input  logic [bpfa_pkg::CFG_W-1:0]         i_cfg_reserved_blocks,
    input  logic [bpfa_pkg::ADDR_W-1:0]        i_page_address,
    output logic [bpfa_pkg::FRAME_ADDR_W-1:0]  o_frame_address,
    output logic [bpfa_pkg::FREE_BYTES_W-1:0]  o_free_bytes
);

    localparam int PAGE_SHIFT = $clog2(FRAME_BYTES);
    localparam int MAP_WORDS  = (NUM_FRAMES + 63) / 64;
    localparam int NUM_GROUPS = (MAP_WORDS + 63) / 64;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int GRP_N      = 1 << GRP_W;
    localparam int MAP_AW     = GRP_W + bpfa_pkg::BIT_W;
    localparam int MAP_DEPTH  = GRP_N * bpfa_pkg::WORD_W;
    localparam int IDX_W      = MAP_AW + bpfa_pkg::BIT_W;
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int WW         = bpfa_pkg::WORD_W;
    localparam int BW         = bpfa_pkg::BIT_W;
    localparam logic [31:0] NF32 = 32'(NUM_FRAMES);

    logic [WW-1:0] map_mem [MAP_DEPTH];
    logic [WW-1:0] sum_mem [GRP_N];

    logic [bpfa_pkg::CFG_W-1:0]   r_reserved;
    logic [bpfa_pkg::ADDR_W-1:0]  r_addr;
    logic [MAP_AW-1:0]            r_sweep;
    logic [CNT_W-1:0]             r_n;
    logic [CNT_W-1:0]             r_used, n_used;
    logic [GRP_W-1:0]             r_grp;
    logic [MAP_AW-1:0]            r_word;
    logic [WW-1:0]                r_sum_q, r_map_q;
    logic [GRP_N-1:0]             r_gfull, n_gfull;
    logic [IDX_W-1:0]             r_frame_idx;
    logic                         r_frame_ok;

    // sweep word contents
    logic [CNT_W-1:0]  n_start;
    logic [31:0]       sw32, nw32, g32, ng32;
    logic [GRP_W-1:0]  sweep_g;
    logic [WW-1:0]     sweep_map_word, sweep_sum_word;
    logic              sweep_gfull, sum_sweep_wr;

    always_comb begin
        if (i_cmd.sweep_clear) begin
            n_start = '0;
        end else if (32'(r_reserved) > NF32) begin
            n_start = CNT_W'(NUM_FRAMES);
        end else begin
            n_start = CNT_W'(r_reserved);
        end
    end

    assign sw32    = 32'(r_sweep);
    assign nw32    = 32'(r_n >> BW);
    assign sweep_g = r_sweep[MAP_AW-1:BW];
    assign g32     = 32'(sweep_g);
    assign ng32    = nw32 >> BW;

    always_comb begin
        if (sw32 < nw32) begin
            sweep_map_word = '1;
        end else if (sw32 == nw32) begin
            sweep_map_word = bpfa_pkg::low_mask(r_n[BW-1:0]);
        end else begin
            sweep_map_word = '0;
        end
        if (g32 < ng32) begin
            sweep_sum_word = '1;
        end else if (g32 == ng32) begin
            sweep_sum_word = bpfa_pkg::low_mask(nw32[BW-1:0]);
        end else begin
            sweep_sum_word = '0;
        end
    end

    assign sweep_gfull  = (g32 < ng32);
    assign sum_sweep_wr = i_cmd.sweep_step && (r_sweep[BW-1:0] == '0);

    // allocation search
    logic              grp_found;
    logic [GRP_W-1:0]  grp_sel;
    logic [BW:0]       fz_sum, fz_map;
    logic [MAP_AW-1:0] word_sel;
    logic [IDX_W-1:0]  new_idx;
    logic              alloc_ok, alloc_wr, alloc_full;
    logic [WW-1:0]     alloc_map_new, alloc_sum_new;

    always_comb begin
        grp_found = 1'b0;
        grp_sel   = '0;
        for (int i = GRP_N - 1; i >= 0; i--) begin
            if (!r_gfull[i]) begin
                grp_found = 1'b1;
                grp_sel   = GRP_W'(i);
            end
        end
    end

    assign fz_sum        = bpfa_pkg::first_zero(r_sum_q);
    assign word_sel      = {r_grp, fz_sum[BW-1:0]};
    assign fz_map        = bpfa_pkg::first_zero(r_map_q);
    assign new_idx       = {r_word, fz_map[BW-1:0]};
    assign alloc_ok      = fz_map[BW] && (32'(new_idx) < NF32);
    assign alloc_wr      = i_cmd.alloc_upd && alloc_ok;
    assign alloc_map_new = r_map_q | (WW'(1) << fz_map[BW-1:0]);
    assign alloc_sum_new = r_sum_q | (WW'(1) << r_word[BW-1:0]);
    assign alloc_full    = &alloc_map_new;

    // free decode
    logic [31:0]        fidx32;
    logic [MAP_AW-1:0]  f_word;
    logic [GRP_W-1:0]   f_grp;
    logic [BW-1:0]      f_bit, f_wbit;
    logic               f_used, free_wr, range_err;
    logic [WW-1:0]      free_map_new, free_sum_new;

    assign fidx32       = r_addr >> PAGE_SHIFT;
    assign f_word       = fidx32[MAP_AW+BW-1:BW];
    assign f_grp        = fidx32[MAP_AW+BW-1:2*BW];
    assign f_bit        = fidx32[BW-1:0];
    assign f_wbit       = fidx32[2*BW-1:BW];
    assign range_err    = (fidx32 >= NF32);
    assign f_used       = r_map_q[f_bit];
    assign free_wr      = i_cmd.free_upd && f_used;
    assign free_map_new = r_map_q & ~(WW'(1) << f_bit);
    assign free_sum_new = r_sum_q & ~(WW'(1) << f_wbit);

    // memory ports
    logic              map_we, map_re, sum_we, sum_re;
    logic [MAP_AW-1:0] map_wa, map_ra;
    logic [GRP_W-1:0]  sum_wa, sum_ra;
    logic [WW-1:0]     map_wd, sum_wd;

    always_comb begin
        map_we = 1'b0;
        map_wa = r_sweep;
        map_wd = sweep_map_word;
        if (i_cmd.sweep_step) begin
            map_we = 1'b1;
        end else if (alloc_wr) begin
            map_we = 1'b1;
            map_wa = r_word;
            map_wd = alloc_map_new;
        end else if (free_wr) begin
            map_we = 1'b1;
            map_wa = f_word;
            map_wd = free_map_new;
        end

        sum_we = 1'b0;
        sum_wa = sweep_g;
        sum_wd = sweep_sum_word;
        if (sum_sweep_wr) begin
            sum_we = 1'b1;
        end else if (alloc_wr && alloc_full) begin
            sum_we = 1'b1;
            sum_wa = r_grp;
            sum_wd = alloc_sum_new;
        end else if (free_wr) begin
            sum_we = 1'b1;
            sum_wa = f_grp;
            sum_wd = free_sum_new;
        end

        map_re = i_cmd.alloc_word || i_cmd.free_rd;
        map_ra = i_cmd.free_rd ? f_word : word_sel;
        sum_re = i_cmd.alloc_grp || i_cmd.free_rd;
        sum_ra = i_cmd.free_rd ? f_grp : grp_sel;
    end

    always_ff @(posedge i_clk) begin
        if (map_we) map_mem[map_wa] <= map_wd;
        if (map_re) r_map_q <= map_mem[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) sum_mem[sum_wa] <= sum_wd;
        if (sum_re) r_sum_q <= sum_mem[sum_ra];
    end

    always_comb begin
        n_gfull = r_gfull;
        if (sum_sweep_wr) begin
            n_gfull[sweep_g] = sweep_gfull;
        end else if (alloc_wr && alloc_full) begin
            n_gfull[r_grp] = &alloc_sum_new;
        end else if (free_wr) begin
            n_gfull[f_grp] = 1'b0;
        end

        n_used = r_used;
        if (i_cmd.sweep_start) begin
            n_used = n_start;
        end else if (alloc_wr) begin
            n_used = r_used + CNT_W'(1);
        end else if (free_wr) begin
            n_used = r_used - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= bpfa_pkg::RESERVED_RST;
            r_gfull    <= '0;
            r_used     <= '0;
            r_sweep    <= '0;
            r_frame_ok <= 1'b0;
        end else begin
            if (i_cfg_we) r_reserved <= i_cfg_reserved_blocks;
            r_gfull <= n_gfull;
            r_used  <= n_used;
            if (i_cmd.sweep_start) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + MAP_AW'(1);
            end
            if (i_cmd.accept) begin
                r_frame_ok <= 1'b0;
            end else if (alloc_wr) begin
                r_frame_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept)      r_addr      <= i_page_address;
        if (i_cmd.sweep_start) r_n         <= n_start;
        if (i_cmd.alloc_grp)   r_grp       <= grp_sel;
        if (i_cmd.alloc_word)  r_word      <= word_sel;
        if (alloc_wr)          r_frame_idx <= new_idx;
    end

    // result fields
    logic [CNT_W-1:0] free_frames;
    logic [63:0]      free_bytes_w, frame_addr_w;

    assign free_frames     = CNT_W'(NUM_FRAMES) - r_used;
    assign free_bytes_w    = 64'(free_frames) << PAGE_SHIFT;
    assign frame_addr_w    = 64'(r_frame_idx) << PAGE_SHIFT;
    assign o_free_bytes    = free_bytes_w[bpfa_pkg::FREE_BYTES_W-1:0];
    assign o_frame_address = r_frame_ok ? frame_addr_w[bpfa_pkg::FRAME_ADDR_W-1:0] : '0;

    assign o_sts.sweep_last   = &r_sweep;
    assign o_sts.grp_none     = !grp_found;
    assign o_sts.alloc_ok     = alloc_ok;
    assign o_sts.range_err    = range_err;
    assign o_sts.already_free = !f_used;

    `BPFA_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(NUM_FRAMES))
    `BPFA_ASSERT_NXT(a_alloc_cnt, i_clk, i_rst_n, alloc_wr, r_used == $past(r_used) + 1'b1)
    `BPFA_ASSERT_NXT(a_free_cnt, i_clk, i_rst_n, free_wr, r_used == $past(r_used) - 1'b1)

endmodule

### rtl/core/bitmap_page_frame_allocator.sv
// Top level of the first-fit bitmap page frame allocator.
// Depends on bpfa_pkg, bpfa_ctrl and bpfa_dpath.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries i_mode and i_page_address.
//   Mode init clears the used map and marks the lowest reserved frames used,
//   alloc takes the lowest free frame, free releases the frame holding the
//   address; the unused mode only reports the free bytes.
//   Result channel (o_out_valid / i_out_ready) returns one transfer per request:
//   o_status, o_frame_address, o_free_bytes.
//   i_cfg_we / i_cfg_reserved_blocks writes the reserved frame count (reset 4096).
// Steps from request transfer to result valid:
//   alloc: group flags, summary word read, map word read, update;
//   init sweeps NUM_FRAMES/64 map words, rounded up to a power-of-two number of
//   64-word groups, one map word per cycle.
//   One request is in flight; the next transfer is taken the cycle after the
//   result is taken.
// Reset: a start step and a clearing pass over every map word, with o_in_ready
//   low. A stalled result holds o_out_valid and its fields.
module bitmap_page_frame_allocator #(
    parameter int NUM_FRAMES  = 32768,
    parameter int FRAME_BYTES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bpfa_pkg::CFG_W-1:0]         i_cfg_reserved_blocks,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [bpfa_pkg::MODE_W-1:0]        i_mode,
    input  logic [bpfa_pkg::ADDR_W-1:0]        i_page_address,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bpfa_pkg::STATUS_W-1:0]      o_status,
    output logic [bpfa_pkg::FRAME_ADDR_W-1:0]  o_frame_address,
    output logic [bpfa_pkg::FREE_BYTES_W-1:0]  o_free_bytes
);

    bpfa_pkg::t_cmd cmd;
    bpfa_pkg::t_sts sts;

    bpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bpfa_dpath #(
        .NUM_FRAMES  (NUM_FRAMES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_reserved_blocks (i_cfg_reserved_blocks),
        .i_page_address        (i_page_address),
        .o_frame_address       (o_frame_address),
        .o_free_bytes          (o_free_bytes)
    );

endmodule

### tb/sv/tb_bitmap_page_frame_allocator.sv
`timescale 1ns / 100ps
// Testbench of bitmap_page_frame_allocator: directed and random init/alloc/free traffic,
// each result checked against a first-fit predictor of the used-frame map.
// Depends on bpfa_pkg and the RTL of the allocator.
module tb_bitmap_page_frame_allocator;

    localparam int NUM_FRAMES  = 32768;
    localparam int FRAME_BYTES = 4096;
    localparam int WORD_W      = bpfa_pkg::WORD_W;
    localparam int MAP_WORDS   = NUM_FRAMES / WORD_W;
    localparam int RANGE_END   = NUM_FRAMES * FRAME_BYTES;
    localparam logic [bpfa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PHASES       = 8;

    typedef struct packed {
        logic [bpfa_pkg::STATUS_W-1:0]     status;
        logic [bpfa_pkg::FRAME_ADDR_W-1:0] frame_address;
        logic [bpfa_pkg::FREE_BYTES_W-1:0] free_bytes;
    } t_alloc_result;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [bpfa_pkg::CFG_W-1:0]        cfg_reserved = '0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [bpfa_pkg::MODE_W-1:0]       req_mode = MODE_UNUSED;
    logic [bpfa_pkg::ADDR_W-1:0]       req_addr = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [bpfa_pkg::STATUS_W-1:0]     res_status;
    logic [bpfa_pkg::FRAME_ADDR_W-1:0] res_frame_address;
    logic [bpfa_pkg::FREE_BYTES_W-1:0] res_free_bytes;

    // predictor state
    logic [WORD_W-1:0]          frame_used [MAP_WORDS];
    int unsigned                used_frames;
    logic [bpfa_pkg::CFG_W-1:0] reserved_frames;
    int unsigned                alloc_frontier;

    t_alloc_result pending_results [$];
    int unsigned   mismatch_count = 0;
    bit            idle_on = 1'b1;

    bitmap_page_frame_allocator #(
        .NUM_FRAMES (NUM_FRAMES),
        .FRAME_BYTES(FRAME_BYTES)
    ) DUT (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_reserved_blocks(cfg_reserved),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_mode               (req_mode),
        .i_page_address       (req_addr),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_status             (res_status),
        .o_frame_address      (res_frame_address),
        .o_free_bytes         (res_free_bytes)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb_bitmap_page_frame_allocator: FAIL");
        $finish;
    end

    function automatic t_alloc_result apply_request(input logic [bpfa_pkg::MODE_W-1:0] mode,
                                                    input logic [bpfa_pkg::ADDR_W-1:0] addr);
        t_alloc_result res;
        int unsigned   n;
        int unsigned   w;
        int unsigned   b;
        int unsigned   idx;
        res = '0;
        res.status = bpfa_pkg::ST_OK;
        case (mode)
            bpfa_pkg::MODE_INIT: begin
                n = reserved_frames;
                if (n > NUM_FRAMES) n = NUM_FRAMES;
                for (w = 0; w < MAP_WORDS; w = w + 1) frame_used[w] = '0;
                for (idx = 0; idx < n; idx = idx + 1) begin
                    frame_used[idx / WORD_W][idx % WORD_W] = 1'b1;
                end
                used_frames = n;
                alloc_frontier = n;
            end
            bpfa_pkg::MODE_ALLOC: begin
                w = 0;
                while (w < MAP_WORDS && frame_used[w] == {WORD_W{1'b1}}) w = w + 1;
                if (w == MAP_WORDS) begin
                    res.status = bpfa_pkg::ST_OOM;
                end else begin
                    b = 0;
                    while (frame_used[w][b]) b = b + 1;
                    idx = w * WORD_W + b;
                    if (idx >= NUM_FRAMES) begin
                        res.status = bpfa_pkg::ST_OOM;
                    end else begin
                        frame_used[w][b] = 1'b1;
                        used_frames = used_frames + 1;
                        res.frame_address = bpfa_pkg::FRAME_ADDR_W'(idx * FRAME_BYTES);
                        if (idx + 1 > alloc_frontier) alloc_frontier = idx + 1;
                    end
                end
            end
            bpfa_pkg::MODE_FREE: begin
                idx = addr / FRAME_BYTES;
                if (idx >= NUM_FRAMES) begin
                    res.status = bpfa_pkg::ST_RANGE;
                end else if (!frame_used[idx / WORD_W][idx % WORD_W]) begin
                    res.status = bpfa_pkg::ST_ALREADY_FREE;
                end else begin
                    frame_used[idx / WORD_W][idx % WORD_W] = 1'b0;
                    used_frames = used_frames - 1;
                end
            end
            default: ;
        endcase
        res.free_bytes = bpfa_pkg::FREE_BYTES_W'(longint'(NUM_FRAMES - used_frames)
                                                 * FRAME_BYTES);
        return res;
    endfunction

    always @(posedge clk) begin : request_track
        int unsigned w;
        if (!rst_n) begin
            for (w = 0; w < MAP_WORDS; w = w + 1) frame_used[w] = '0;
            used_frames = 0;
            reserved_frames = bpfa_pkg::RESERVED_RST;
            alloc_frontier = 0;
        end else begin
            if (cfg_we) reserved_frames = cfg_reserved;
            if (in_valid && in_ready) pending_results.push_back(apply_request(req_mode, req_addr));
        end
    end

    task automatic note_mismatch(input string what, input t_alloc_result want,
                                 input t_alloc_result seen);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected %0d/%h/%h, got %0d/%h/%h",
                     $realtime, what, want.status, want.frame_address, want.free_bytes,
                     seen.status, seen.frame_address, seen.free_bytes);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_alloc_result seen;
        t_alloc_result want;
        if (rst_n && out_valid && out_ready) begin
            seen = {res_status, res_frame_address, res_free_bytes};
            if (pending_results.size() == 0) begin
                note_mismatch("result with no request outstanding", '0, seen);
            end else begin
                want = pending_results.pop_front();
                if (seen !== want) note_mismatch("result mismatch", want, seen);
            end
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [bpfa_pkg::MODE_W-1:0] mode,
                                input logic [bpfa_pkg::ADDR_W-1:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_mode <= mode;
        req_addr <= addr;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic set_reserved(input logic [bpfa_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_reserved <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_before_init();
        send_request(MODE_UNUSED, $urandom());
        send_request(bpfa_pkg::MODE_ALLOC, $urandom());
        send_request(bpfa_pkg::MODE_FREE, 32'h0000_0000);
    endtask

    // reserved count still at its reset value
    task automatic test_init_default();
        send_request(bpfa_pkg::MODE_INIT, $urandom());
        send_request(bpfa_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
        send_request(bpfa_pkg::MODE_FREE,
                     32'(bpfa_pkg::RESERVED_RST) * FRAME_BYTES + FRAME_BYTES - 1);
        send_request(bpfa_pkg::MODE_FREE, 32'h0000_0FFF);
        send_request(bpfa_pkg::MODE_ALLOC, 32'h0000_0000);
    endtask

    task automatic test_free_errors();
        send_request(bpfa_pkg::MODE_FREE, RANGE_END);
        send_request(bpfa_pkg::MODE_FREE, 32'hFFFF_FFFF);
        send_request(bpfa_pkg::MODE_FREE, RANGE_END - 1);
        send_request(bpfa_pkg::MODE_FREE, RANGE_END - FRAME_BYTES);
    endtask

    task automatic test_zero_reserved();
        set_reserved('0);
        send_request(bpfa_pkg::MODE_INIT, '0);
        send_request(bpfa_pkg::MODE_ALLOC, '0);
        send_request(bpfa_pkg::MODE_FREE, '0);
    endtask

    task automatic test_oversized_reserved();
        set_reserved({bpfa_pkg::CFG_W{1'b1}});
        send_request(bpfa_pkg::MODE_INIT, $urandom());
        send_request(bpfa_pkg::MODE_ALLOC, $urandom());
        send_request(bpfa_pkg::MODE_FREE, RANGE_END - FRAME_BYTES);
        send_request(bpfa_pkg::MODE_ALLOC, $urandom());
        send_request(bpfa_pkg::MODE_ALLOC, $urandom());
    endtask

    task automatic test_full_reserved();
        set_reserved(bpfa_pkg::CFG_W'(NUM_FRAMES));
        send_request(bpfa_pkg::MODE_INIT, $urandom());
        send_request(bpfa_pkg::MODE_FREE, '0);
        send_request(bpfa_pkg::MODE_ALLOC, $urandom());
    endtask

    // Churn near the allocation frontier: valid frees, double frees, refills,
    // out-of-memory runs when the reserved count is close to the map size.
    task automatic test_random_traffic();
        int unsigned                 phase;
        int unsigned                 sent;
        int unsigned                 sel;
        int unsigned                 lo;
        int unsigned                 hi;
        int unsigned                 idx;
        logic [bpfa_pkg::CFG_W-1:0]  reserve;
        logic [bpfa_pkg::ADDR_W-1:0] addr;
        for (phase = 0; phase < PHASES; phase = phase + 1) begin
            case (phase)
                0: reserve = bpfa_pkg::CFG_W'($urandom_range(0, 64));
                1: reserve = bpfa_pkg::RESERVED_RST;
                2: reserve = bpfa_pkg::CFG_W'(NUM_FRAMES - $urandom_range(0, 40));
                3: reserve = bpfa_pkg::CFG_W'($urandom_range(0, 65535));
                4: reserve = {bpfa_pkg::CFG_W{1'b1}};
                5: reserve = bpfa_pkg::CFG_W'(NUM_FRAMES - $urandom_range(1, 8));
                6: reserve = '0;
                default: reserve = bpfa_pkg::CFG_W'($urandom_range(NUM_FRAMES - 64,
                                                                   NUM_FRAMES));
            endcase
            set_reserved(reserve);
            idle_on = (phase != 2 && phase != PHASES - 1);
            send_request(bpfa_pkg::MODE_INIT, $urandom());
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                sel = $urandom_range(0, 99);
                if (sel < 3) begin
                    send_request(MODE_UNUSED, $urandom());
                end else if (sel < 5) begin
                    send_request(bpfa_pkg::MODE_INIT, $urandom());
                    sent++;
                end else if (sel < 50) begin
                    send_request(bpfa_pkg::MODE_ALLOC, $urandom());
                    sent++;
                end else begin
                    sel = $urandom_range(0, 99);
                    hi = alloc_frontier + 4;
                    if (hi > NUM_FRAMES - 1) hi = NUM_FRAMES - 1;
                    lo = (alloc_frontier > 200) ? alloc_frontier - 200 : 0;
                    if (lo > hi) lo = hi;
                    idx = (sel < 20) ? $urandom_range(0, NUM_FRAMES - 1) : $urandom_range(lo, hi);
                    addr = 32'(idx * FRAME_BYTES);
                    if ($urandom_range(0, 1) == 1) addr = addr + ($urandom() % FRAME_BYTES);
                    if (sel < 8) addr = $urandom_range(32'hFFFF_FFFF, RANGE_END);
                    else if (sel < 12) addr = $urandom();
                    send_request(bpfa_pkg::MODE_FREE, addr);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_before_init();
        test_init_default();
        test_free_errors();
        test_zero_reserved();
        test_oversized_reserved();
        test_full_reserved();
        test_random_traffic();
        wait_idle();
        repeat (600) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_bitmap_page_frame_allocator: PASS");
        end else begin
            $display("tb_bitmap_page_frame_allocator: FAIL");
        end
        $finish;
    end

endmodule
